/* rtl/cmu_pkg.sv */
// cmu_pkg: shared constants, codes and types of the context memory unit.
// Used by every module under rtl but cmu_ram; depends on nothing.
package cmu_pkg;

   localparam int MAX_CONTEXTS = 64;
   localparam int SPACE_BITS   = 16;
   localparam int SPACE_DEPTH  = 2 ** SPACE_BITS;

   localparam int CMD_W    = 3;
   localparam int ID_W     = 6;
   localparam int ADDR_W   = SPACE_BITS;
   localparam int SIZE_W   = 17;
   localparam int DATA_W   = 8;
   localparam int STATUS_W = 4;
   localparam int NID_W    = 7;          // holds MAX_CONTEXTS itself
   localparam int TBL_W    = ADDR_W + SIZE_W;

   localparam logic [SIZE_W-1:0] MAX_CONTEXT_BYTES = 17'd65536;
   localparam logic [SIZE_W:0]   SPACE_END = (SIZE_W + 1)'(64'd1 << SPACE_BITS);

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 56;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // command codes on the request channel
   localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd1;
   localparam logic [CMD_W-1:0] CMD_READ    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_FIND    = 3'd5;

   typedef enum logic [2:0] {
      OP_CREATE,
      OP_DESTROY,
      OP_READ,
      OP_WRITE,
      OP_QUERY,
      OP_FIND,
      OP_NOP
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 4'd0,
      ST_PROTECTED    = 4'd1,
      ST_ZERO_SIZE    = 4'd2,
      ST_TOO_LARGE    = 4'd3,
      ST_EXHAUSTED    = 4'd4,
      ST_NO_CONTEXT   = 4'd5,
      ST_OUT_OF_RANGE = 4'd6,
      ST_TABLE_FULL   = 4'd7,
      ST_NOT_FOUND    = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_LOOK,
      BK_BYTE
   } back_state_type;

   typedef struct packed {
      op_type              op;
      status_type          pre_status;
      logic [ID_W-1:0]     ctx_id;
      logic [ADDR_W-1:0]   addr;
      logic [SIZE_W-1:0]   size;
      logic [DATA_W-1:0]   wdata;
   } item_type;

   typedef struct packed {
      status_type          status;
      logic [ID_W-1:0]     out_id;
      logic [ADDR_W-1:0]   out_base;
      logic [SIZE_W-1:0]   out_size;
      logic [DATA_W-1:0]   rdata;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* rtl/context_memory_unit.sv */
// context_memory_unit: top level of the base-and-bounds context memory unit.
// Depends on cmu_pkg, cmu_front, cmu_queue, cmu_back (and cmu_ram below it).
//
//   channel  dir  handshake            payload
//   req      in   req_tvalid/tready    tuser: cmd; tdata: ctx_id, addr, req_size, wdata
//   rsp      out  rsp_tvalid/tready    tdata: status, out_id, out_base, out_size, rdata
//   csr      in   csr_valid/ready      csr_wdata: protected_mode
//
// In the back end create, destroy, write, query and unknown commands go through
// BK_IDLE and BK_LOOK; read also through BK_BYTE (table read, then byte store read).
// Find walks the context table one entry a cycle and scans only the entries
// below the number of ids handed out so far, stopping at the first hit.
// After reset a pass over all 65536 bytes zeroes the byte store; req_tready stays low
// until it ends, csr writes are taken throughout.
// A 2-entry queue keeps requests flowing while a result waits on rsp_tready.
module context_memory_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [2:0] cmd
   input  logic [cmu_pkg::CMD_W-1:0]        req_tuser,
   // [5:0] ctx_id, [21:6] addr, [38:22] req_size, [46:39] wdata
   input  logic [cmu_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [3:0] status, [9:4] out_id, [25:10] out_base, [42:26] out_size, [50:43] rdata
   output logic [cmu_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_wdata
);

   cmu_pkg::queue_status_type  q_status;
   cmu_pkg::item_type          push_item, head;
   cmu_pkg::result_type        rsp_result;
   logic                       push, pop, clearing;

   cmu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .clearing   (clearing),
      .push       (push),
      .push_item  (push_item)
   );

   cmu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .q_status  (q_status)
   );

   cmu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head       (head),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {5'b00000, rsp_result.rdata, rsp_result.out_size,
                       rsp_result.out_base, rsp_result.out_id, rsp_result.status};

endmodule

/* rtl/cmu_ram.sv */
// cmu_ram: generic single write port, single read port RAM, registered read.
// Standalone; no package needed.
module cmu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while rd_en is low
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/cmu_front.sv */
// cmu_front: request intake, configuration register and command classification.
// Depends on cmu_pkg; feeds cmu_queue.
module cmu_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [cmu_pkg::CMD_W-1:0]        req_tuser,   // cmd
   input  logic [cmu_pkg::REQ_TDATA_W-1:0]  req_tdata,   // ctx_id, addr, req_size, wdata
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_wdata,
   input  cmu_pkg::queue_status_type        q_status,
   input  logic                             clearing,
   output logic                             push,
   output cmu_pkg::item_type                push_item
);

   logic protected_ff;
   logic protected_in;

   assign csr_ready = 1'b1;

   always_comb begin
      protected_in = protected_ff;
      if (csr_valid) begin
         protected_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         protected_ff <= 1'b0;
      end else begin
         protected_ff <= protected_in;
      end
   end

   assign req_tready = !q_status.full && !clearing;
   assign push       = req_tvalid && req_tready;

   // static checks that need no table state are settled here
   always_comb begin
      push_item.ctx_id     = req_tdata[5:0];
      push_item.addr       = req_tdata[21:6];
      push_item.size       = req_tdata[38:22];
      push_item.wdata      = req_tdata[46:39];
      push_item.pre_status = cmu_pkg::ST_OK;
      case (req_tuser)
         cmu_pkg::CMD_CREATE: begin
            push_item.op = cmu_pkg::OP_CREATE;
            if (protected_ff) begin
               push_item.pre_status = cmu_pkg::ST_PROTECTED;
            end else if (push_item.size == '0) begin
               push_item.pre_status = cmu_pkg::ST_ZERO_SIZE;
            end else if (push_item.size > cmu_pkg::MAX_CONTEXT_BYTES) begin
               push_item.pre_status = cmu_pkg::ST_TOO_LARGE;
            end
         end
         cmu_pkg::CMD_DESTROY: begin
            push_item.op = cmu_pkg::OP_DESTROY;
            if (protected_ff) begin
               push_item.pre_status = cmu_pkg::ST_PROTECTED;
            end
         end
         cmu_pkg::CMD_READ:  push_item.op = cmu_pkg::OP_READ;
         cmu_pkg::CMD_WRITE: push_item.op = cmu_pkg::OP_WRITE;
         cmu_pkg::CMD_QUERY: push_item.op = cmu_pkg::OP_QUERY;
         cmu_pkg::CMD_FIND:  push_item.op = cmu_pkg::OP_FIND;
         default:            push_item.op = cmu_pkg::OP_NOP;
      endcase
   end

endmodule

/* rtl/cmu_queue.sv */
// cmu_queue: short FIFO of classified items between front and back.
// Depends on cmu_pkg.
module cmu_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  cmu_pkg::item_type          push_item,
   input  logic                       pop,
   output cmu_pkg::item_type          head,
   output cmu_pkg::queue_status_type  q_status
);

   cmu_pkg::item_type                entry_ff [cmu_pkg::QUEUE_DEPTH];
   logic [cmu_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [cmu_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [cmu_pkg::QCNT_W-1:0]       count_ff, count_in;

   function automatic logic [cmu_pkg::QPTR_W-1:0] ptr_next(
      input logic [cmu_pkg::QPTR_W-1:0] ptr
   );
      if (ptr == cmu_pkg::QPTR_W'(cmu_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   assign head           = entry_ff[rd_ptr_ff];
   assign q_status.full  = count_ff == cmu_pkg::QCNT_W'(cmu_pkg::QUEUE_DEPTH);
   assign q_status.empty = count_ff == '0;

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/cmu_back.sv */
// cmu_back: executes queued items against the context table and byte store,
// holds the result register. Depends on cmu_pkg and cmu_ram.
module cmu_back (
   input  logic                       clock,
   input  logic                       reset,
   input  cmu_pkg::queue_status_type  q_status,
   input  cmu_pkg::item_type          head,
   output logic                       pop,
   output logic                       clearing,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output cmu_pkg::result_type        rsp_result
);

   cmu_pkg::back_state_type             state_ff, state_in;
   cmu_pkg::item_type                   cur_ff, cur_in;
   logic [cmu_pkg::ID_W-1:0]            scan_ff, scan_in;
   logic [cmu_pkg::MAX_CONTEXTS-1:0]    valid_ff, valid_in;
   logic [cmu_pkg::NID_W-1:0]           next_id_ff, next_id_in;
   logic [cmu_pkg::SIZE_W-1:0]          next_free_ff, next_free_in;
   logic [cmu_pkg::SPACE_BITS-1:0]      clr_ff, clr_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   cmu_pkg::result_type                 rsp_ff, rsp_in;

   logic                                tbl_wr_en, tbl_rd_en;
   logic [cmu_pkg::ID_W-1:0]            tbl_wr_addr, tbl_rd_addr;
   logic [cmu_pkg::TBL_W-1:0]           tbl_wr_data, tbl_rd_data;
   logic                                byte_wr_en, byte_rd_en;
   logic [cmu_pkg::SPACE_BITS-1:0]      byte_wr_addr, byte_rd_addr;
   logic [cmu_pkg::DATA_W-1:0]          byte_wr_data, byte_rd_data;

   logic [cmu_pkg::ADDR_W-1:0]          tbl_base;
   logic [cmu_pkg::SIZE_W-1:0]          tbl_len;
   logic                                out_free, known, in_range, exhausted, tbl_full;
   logic                                hit, scan_last, emit;
   logic [cmu_pkg::ADDR_W:0]            loc_sum;
   logic [cmu_pkg::SPACE_BITS-1:0]      loc;
   logic [cmu_pkg::SIZE_W:0]            create_end, region_end;
   logic [cmu_pkg::NID_W-1:0]           scan_plus;
   cmu_pkg::result_type                 res;

   cmu_ram #(
      .WIDTH (cmu_pkg::TBL_W),
      .DEPTH (cmu_pkg::MAX_CONTEXTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   cmu_ram #(
      .WIDTH (cmu_pkg::DATA_W),
      .DEPTH (cmu_pkg::SPACE_DEPTH)
   ) u_bytes (
      .clock   (clock),
      .wr_en   (byte_wr_en),
      .wr_addr (byte_wr_addr),
      .wr_data (byte_wr_data),
      .rd_en   (byte_rd_en),
      .rd_addr (byte_rd_addr),
      .rd_data (byte_rd_data)
   );

   // table word: length above base
   assign tbl_base = tbl_rd_data[cmu_pkg::ADDR_W-1:0];
   assign tbl_len  = tbl_rd_data[cmu_pkg::TBL_W-1:cmu_pkg::ADDR_W];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign known      = valid_ff[cur_ff.ctx_id];
   assign in_range   = {1'b0, cur_ff.addr} < tbl_len;
   assign loc_sum    = {1'b0, tbl_base} + {1'b0, cur_ff.addr};
   assign loc        = loc_sum[cmu_pkg::SPACE_BITS-1:0];
   assign create_end = {1'b0, next_free_ff} + {1'b0, cur_ff.size};
   assign exhausted  = create_end > cmu_pkg::SPACE_END;
   assign tbl_full   = next_id_ff >= cmu_pkg::NID_W'(cmu_pkg::MAX_CONTEXTS);
   assign region_end = {2'b00, tbl_base} + {1'b0, tbl_len};
   assign hit        = valid_ff[scan_ff] && (cur_ff.addr >= tbl_base)
                       && ({2'b00, cur_ff.addr} < region_end);
   assign scan_plus  = {1'b0, scan_ff} + 1'b1;
   // entries at or above next_id were never created
   assign scan_last  = scan_plus >= next_id_ff;

   assign clearing   = state_ff == cmu_pkg::BK_CLEAR;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      scan_in      = scan_ff;
      valid_in     = valid_ff;
      next_id_in   = next_id_ff;
      next_free_in = next_free_ff;
      clr_in       = clr_ff;
      pop          = 1'b0;
      emit         = 1'b0;
      res          = '0;
      tbl_wr_en    = 1'b0;
      tbl_wr_addr  = next_id_ff[cmu_pkg::ID_W-1:0];
      tbl_wr_data  = {cur_ff.size, next_free_ff[cmu_pkg::ADDR_W-1:0]};
      tbl_rd_en    = 1'b0;
      tbl_rd_addr  = head.ctx_id;
      byte_wr_en   = 1'b0;
      byte_wr_addr = loc;
      byte_wr_data = cur_ff.wdata;
      byte_rd_en   = 1'b0;
      byte_rd_addr = loc;

      case (state_ff)
         cmu_pkg::BK_CLEAR: begin
            // zero fill stands in for per-byte written marks
            byte_wr_en   = 1'b1;
            byte_wr_addr = clr_ff;
            byte_wr_data = '0;
            clr_in       = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = cmu_pkg::BK_IDLE;
            end
         end

         cmu_pkg::BK_IDLE: begin
            if (!q_status.empty) begin
               pop       = 1'b1;
               cur_in    = head;
               tbl_rd_en = 1'b1;
               scan_in   = '0;
               if (head.op == cmu_pkg::OP_FIND) begin
                  tbl_rd_addr = '0;
               end
               state_in  = cmu_pkg::BK_LOOK;
            end
         end

         cmu_pkg::BK_LOOK: begin
            case (cur_ff.op)
               cmu_pkg::OP_CREATE: begin
                  emit = out_free;
                  if (cur_ff.pre_status != cmu_pkg::ST_OK) begin
                     res.status = cur_ff.pre_status;
                  end else if (exhausted) begin
                     res.status = cmu_pkg::ST_EXHAUSTED;
                  end else if (tbl_full) begin
                     res.status = cmu_pkg::ST_TABLE_FULL;
                  end else begin
                     res.status   = cmu_pkg::ST_OK;
                     res.out_id   = next_id_ff[cmu_pkg::ID_W-1:0];
                     res.out_base = next_free_ff[cmu_pkg::ADDR_W-1:0];
                     res.out_size = cur_ff.size;
                     if (emit) begin
                        tbl_wr_en    = 1'b1;
                        valid_in[next_id_ff[cmu_pkg::ID_W-1:0]] = 1'b1;
                        next_id_in   = next_id_ff + 1'b1;
                        next_free_in = create_end[cmu_pkg::SIZE_W-1:0];
                     end
                  end
               end

               cmu_pkg::OP_DESTROY: begin
                  emit = out_free;
                  if (cur_ff.pre_status != cmu_pkg::ST_OK) begin
                     res.status = cur_ff.pre_status;
                  end else if (!known) begin
                     res.status = cmu_pkg::ST_NO_CONTEXT;
                  end else if (emit) begin
                     valid_in[cur_ff.ctx_id] = 1'b0;
                  end
               end

               cmu_pkg::OP_READ: begin
                  if (!known) begin
                     res.status = cmu_pkg::ST_NO_CONTEXT;
                     emit       = out_free;
                  end else if (!in_range) begin
                     res.status = cmu_pkg::ST_OUT_OF_RANGE;
                     emit       = out_free;
                  end else begin
                     byte_rd_en = 1'b1;
                     state_in   = cmu_pkg::BK_BYTE;
                  end
               end

               cmu_pkg::OP_WRITE: begin
                  emit = out_free;
                  if (!known) begin
                     res.status = cmu_pkg::ST_NO_CONTEXT;
                  end else if (!in_range) begin
                     res.status = cmu_pkg::ST_OUT_OF_RANGE;
                  end else begin
                     byte_wr_en = emit;
                  end
               end

               cmu_pkg::OP_QUERY: begin
                  emit = out_free;
                  if (!known) begin
                     res.status = cmu_pkg::ST_NO_CONTEXT;
                  end else begin
                     res.out_id   = cur_ff.ctx_id;
                     res.out_base = tbl_base;
                     res.out_size = tbl_len;
                  end
               end

               cmu_pkg::OP_FIND: begin
                  // one table entry per cycle, lowest id first
                  if (hit) begin
                     emit         = out_free;
                     res.out_id   = scan_ff;
                     res.out_base = tbl_base;
                     res.out_size = tbl_len;
                  end else if (scan_last) begin
                     emit       = out_free;
                     res.status = cmu_pkg::ST_NOT_FOUND;
                  end else begin
                     tbl_rd_en   = 1'b1;
                     tbl_rd_addr = scan_plus[cmu_pkg::ID_W-1:0];
                     scan_in     = scan_plus[cmu_pkg::ID_W-1:0];
                  end
               end

               default: begin
                  emit = out_free;
               end
            endcase
            if (emit) begin
               state_in = cmu_pkg::BK_IDLE;
            end
         end

         cmu_pkg::BK_BYTE: begin
            res.rdata = byte_rd_data;
            emit      = out_free;
            if (emit) begin
               state_in = cmu_pkg::BK_IDLE;
            end
         end

         default: begin
            state_in = cmu_pkg::BK_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cmu_pkg::BK_CLEAR;
         valid_ff     <= '0;
         next_id_ff   <= '0;
         next_free_ff <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         next_id_ff   <= next_id_in;
         next_free_ff <= next_free_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      scan_ff <= scan_in;
      rsp_ff  <= rsp_in;
   end

endmodule
